// ----- src/slpo_pkg.sv -----
package slpo_pkg;

  // sample and register widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned PcmW    = 16;
  localparam int unsigned CoefW   = 15;
  localparam int unsigned FmtW    = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_ON  = 2'd0,
    CFG_COEF_A     = 2'd1,
    CFG_OUT_FORMAT = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_FIN
  } state_e;

  // step that a lane performs this cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD1,
    OP_MUL2,
    OP_ADD2
  } lane_op_e;

  // control shared by both lanes
  typedef struct packed {
    lane_op_e op;
    logic     filter_on;
    logic     clear;
  } lane_ctrl_t;

endpackage

// ----- src/slpo_lane.sv -----
module slpo_lane (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  slpo_pkg::lane_ctrl_t                  ctrl_i,
  input  logic        [slpo_pkg::CoefW-1:0]     coef_i,
  input  logic signed [slpo_pkg::SampleW-1:0]   x_i,
  output logic signed [slpo_pkg::SampleW-1:0]   y_o
);
  import slpo_pkg::*;

  localparam int unsigned DiffW = SampleW + 1;
  localparam int unsigned ProdW = DiffW + CoefW + 1;
  localparam int unsigned SumW  = ProdW + 1;

  logic signed [SampleW-1:0] hist_q [2];
  logic signed [SampleW-1:0] y_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [ProdW-1:0]   prod_d;
  logic signed [DiffW-1:0]   diff;
  logic signed [CoefW:0]     coef_s;
  logic        [SumW-1:0]    sum;
  logic        [SumW-1:0]    rnd;
  logic signed [SampleW-1:0] y_new;

  // multiplier operand: h - x for the active pole stage
  always_comb begin
    if (ctrl_i.op == OP_LOAD) begin
      diff = {hist_q[0][SampleW-1], hist_q[0]} - {x_i[SampleW-1], x_i};
    end else begin
      diff = {hist_q[1][SampleW-1], hist_q[1]} - {y_q[SampleW-1], y_q};
    end
  end

  assign coef_s = {1'b0, coef_i};
  assign prod_d = coef_s * diff;

  // x*32768 + product, then divide by 32768 truncating toward zero
  assign sum   = {{(SumW-SampleW-CoefW){y_q[SampleW-1]}}, y_q, {CoefW{1'b0}}}
               + {prod_q[ProdW-1], prod_q};
  assign rnd   = sum[SumW-1] ? sum + SumW'({CoefW{1'b1}}) : sum;
  assign y_new = rnd[CoefW +: SampleW];

  // history of the two pole stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
    end else if (ctrl_i.clear || (ctrl_i.op == OP_LOAD && !ctrl_i.filter_on)) begin
      hist_q[0] <= '0;
      hist_q[1] <= '0;
    end else if (ctrl_i.op == OP_ADD1) begin
      hist_q[0] <= y_new;
    end else if (ctrl_i.op == OP_ADD2) begin
      hist_q[1] <= y_new;
    end
  end

  // working sample and product
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_LOAD: begin
        y_q    <= x_i;
        prod_q <= prod_d;
      end
      OP_ADD1: y_q    <= y_new;
      OP_MUL2: prod_q <= prod_d;
      OP_ADD2: y_q    <= y_new;
      default: ;
    endcase
  end

  assign y_o = y_q;

endmodule

// ----- src/slpo_merge.sv -----
module slpo_merge (
  input  logic signed [slpo_pkg::SampleW-1:0] left_i,
  input  logic signed [slpo_pkg::SampleW-1:0] right_i,
  input  logic        [slpo_pkg::FmtW-1:0]    format_i,
  output logic signed [slpo_pkg::PcmW-1:0]    out_left_o,
  output logic signed [slpo_pkg::PcmW-1:0]    out_right_o
);
  import slpo_pkg::*;

  localparam int unsigned TopW = SampleW - 8 - PcmW + 1;

  logic mono;
  logic eight;

  // shift by 8, saturate to 16 bits, optional offset-binary byte
  function automatic logic [PcmW-1:0] to_pcm(input logic [SampleW-1:0] v, input logic e8);
    logic [TopW-1:0] top;
    logic [PcmW-1:0] s;
    top = v[SampleW-1 -: TopW];
    if (top == '0 || top == '1) begin
      s = v[8 +: PcmW];
    end else if (v[SampleW-1]) begin
      s = {1'b1, {(PcmW-1){1'b0}}};
    end else begin
      s = {1'b0, {(PcmW-1){1'b1}}};
    end
    if (e8) begin
      s = {8'd0, ~s[PcmW-1], s[PcmW-2:8]};
    end
    return s;
  endfunction

  assign mono  = format_i[0];
  assign eight = format_i[1];

  // left always, right only in stereo formats
  assign out_left_o  = to_pcm(left_i, eight);
  assign out_right_o = mono ? '0 : to_pcm(right_i, eight);

endmodule

// ----- src/stereo_lowpass_output_stage.sv -----
// stereo low-pass output stage
// input channel: in_valid_i/in_ready_o carry one stereo pair (mix_left_i,
// mix_right_i, block_end_i); output channel: out_valid_o/out_ready_i carry
// one pcm pair (out_left_o, out_right_o, block_last_o) per input pair.
// configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 filter_on, 1 coef_a, 2 out_format); writing coef_a clears the
// filter history.
// with the filter on, one lane per channel runs its two pole stages
// through its own multiplier, the first multiply in the accept cycle,
// then add, multiply and add cycles, then a format cycle that loads the
// output register and overlaps the next accept.
// with the filter off a pair goes straight to the format step, and a
// pair is taken every cycle while the output register is free.
// the next pair is accepted in the cycle the output register is loaded.
// when the receiver stalls, the result waits in the output register and
// the sequencer holds in its format step, where it takes no input.
// reset clears the config registers, the history and all valid state.
module stereo_lowpass_output_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [slpo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [slpo_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [slpo_pkg::SampleW-1:0]  mix_left_i,
  input  logic signed [slpo_pkg::SampleW-1:0]  mix_right_i,
  input  logic                                 block_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [slpo_pkg::PcmW-1:0]     out_left_o,
  output logic signed [slpo_pkg::PcmW-1:0]     out_right_o,
  output logic                                 block_last_o
);
  import slpo_pkg::*;

  state_e            state_q, state_d;
  logic              filter_on_q;
  logic [CoefW-1:0]  coef_a_q;
  logic [FmtW-1:0]   out_format_q;
  logic              block_q;
  logic              out_valid_q;
  logic [PcmW-1:0]   out_left_q, out_right_q;
  logic              out_last_q;
  logic              out_free;
  logic              accept;
  logic              out_load;
  lane_ctrl_t        ctrl;
  logic signed [SampleW-1:0] y_left, y_right;
  logic signed [PcmW-1:0]    pcm_left, pcm_right;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_on_q  <= 1'b0;
      coef_a_q     <= '0;
      out_format_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILTER_ON:  filter_on_q  <= cfg_data_i[0];
        CFG_COEF_A:     coef_a_q     <= cfg_data_i[CoefW-1:0];
        CFG_OUT_FORMAT: out_format_q <= cfg_data_i[FmtW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = filter_on_q ? ST_ADD1 : ST_FIN;
      end
      ST_ADD1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_ADD2;
      ST_ADD2: state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          if (in_valid_i) state_d = filter_on_q ? ST_ADD1 : ST_FIN;
          else            state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    ctrl.op    = OP_NONE;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_ADD1: ctrl.op = OP_ADD1;
      ST_MUL2: ctrl.op = OP_MUL2;
      ST_ADD2: ctrl.op = OP_ADD2;
      ST_FIN: begin
        in_ready_o = out_free;
        out_load   = out_free;
      end
      default: ;
    endcase
    accept = in_valid_i && in_ready_o;
    if (accept) ctrl.op = OP_LOAD;
    ctrl.filter_on = filter_on_q;
    ctrl.clear     = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_COEF_A);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // block marker travels with the pair
  always_ff @(posedge clk_i) begin
    if (accept) block_q <= block_end_i;
  end

  // one lane per channel
  slpo_lane u_lane_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .coef_i (coef_a_q),
    .x_i    (mix_left_i),
    .y_o    (y_left)
  );

  slpo_lane u_lane_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .coef_i (coef_a_q),
    .x_i    (mix_right_i),
    .y_o    (y_right)
  );

  // pcm conversion of both lanes
  slpo_merge u_merge (
    .left_i      (y_left),
    .right_i     (y_right),
    .format_i    (out_format_q),
    .out_left_o  (pcm_left),
    .out_right_o (pcm_right)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= pcm_left;
      out_right_q <= pcm_right;
      out_last_q  <= block_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_left_o   = out_left_q;
  assign out_right_o  = out_right_q;
  assign block_last_o = out_last_q;

`ifndef NO_ASSERTIONS
  // a stalled result blocks new input in the format step
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && state_q == ST_FIN) |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // filtered transaction starts the pole sequence
  a_filter_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && filter_on_q) |=> state_q == ST_ADD1)
    else $error("filtered transaction did not enter pole sequence");

  // results are only loaded from the format step
  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_FIN)
    else $error("output valid raised outside format step");
`endif

endmodule

// ----- tb/slpo_pcm_checker.sv -----
module slpo_pcm_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [slpo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic        [slpo_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [slpo_pkg::SampleW-1:0]  mix_left_i,
  input  logic signed [slpo_pkg::SampleW-1:0]  mix_right_i,
  input  logic                                 block_end_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [slpo_pkg::PcmW-1:0]     out_left_i,
  input  logic signed [slpo_pkg::PcmW-1:0]     out_right_i,
  input  logic                                 block_last_i,
  output int                                   mismatches_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import slpo_pkg::*;

  typedef struct {
    logic signed [PcmW-1:0] left;
    logic signed [PcmW-1:0] right;
    logic                   last;
  } pcm_pair_t;

  // shadow of the block's registers and filter history
  logic             filter_en;
  logic [CoefW-1:0] coef;
  logic [FmtW-1:0]  fmt;
  longint           pole_hist [4];

  pcm_pair_t expected_pcm_q [$];
  int        mismatch_cnt;

  // one pole stage in q0.15, truncated toward zero; the new history is the result
  function automatic longint one_pole(longint x, longint h, logic [CoefW-1:0] a);
    longint av;
    longint s;
    av = longint'(a);
    s  = x * 32768 + av * (h - x);
    return s / 32768;
  endfunction

  // shift down to 16 bits, saturate, optionally convert to 8-bit offset binary
  function automatic logic [PcmW-1:0] to_pcm(longint v, logic eight_bit);
    longint s;
    s = v >>> 8;
    if (s > 32767) begin
      s = 32767;
    end else if (s < -32768) begin
      s = -32768;
    end
    if (eight_bit) begin
      s = (s + 32768) >>> 8;
    end
    return s[PcmW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint    l;
    longint    r;
    pcm_pair_t want;
    if (!rst_ni) begin
      filter_en    = 1'b0;
      coef         = '0;
      fmt          = '0;
      pole_hist    = '{default: 0};
      expected_pcm_q.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // register writes, only issued while the block is idle
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FILTER_ON:  filter_en = cfg_data_i[0];
          CFG_COEF_A: begin
            coef      = cfg_data_i[CoefW-1:0];
            pole_hist = '{default: 0};
          end
          CFG_OUT_FORMAT: fmt = cfg_data_i[FmtW-1:0];
          default: ;
        endcase
      end

      // compare an output transaction with the oldest expected pair
      if (out_valid_i && out_ready_i) begin
        if (expected_pcm_q.size() == 0) begin
          $error("output transaction with no pair expected");
          mismatch_cnt++;
        end else begin
          want = expected_pcm_q.pop_front();
          if (out_left_i !== want.left) begin
            $error("out_left: expected %0d, got %0d", want.left, out_left_i);
            mismatch_cnt++;
          end
          if (out_right_i !== want.right) begin
            $error("out_right: expected %0d, got %0d", want.right, out_right_i);
            mismatch_cnt++;
          end
          if (block_last_i !== want.last) begin
            $error("block_last: expected %0d, got %0d", want.last, block_last_i);
            mismatch_cnt++;
          end
        end
      end

      // predict the pcm pair for an input transaction
      if (in_valid_i && in_ready_i) begin
        l = longint'(mix_left_i);
        r = longint'(mix_right_i);
        if (filter_en) begin
          l = one_pole(l, pole_hist[0], coef);
          pole_hist[0] = l;
          l = one_pole(l, pole_hist[1], coef);
          pole_hist[1] = l;
          r = one_pole(r, pole_hist[2], coef);
          pole_hist[2] = r;
          r = one_pole(r, pole_hist[3], coef);
          pole_hist[3] = r;
        end else begin
          pole_hist = '{default: 0};
        end
        want.left  = to_pcm(l, fmt[1]);
        want.right = fmt[0] ? '0 : to_pcm(r, fmt[1]);
        want.last  = block_end_i;
        expected_pcm_q.push_back(want);
      end

      mismatches_o <= mismatch_cnt;
      pending_o    <= expected_pcm_q.size();
    end
  end

endmodule

// ----- tb/stereo_lowpass_output_stage_tb.sv -----
module stereo_lowpass_output_stage_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slpo_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int          HoldCycles  = 300;
  localparam int          PhaseItems  = 139;
  localparam int          NumPhases   = 9;

  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx   = '0;
  logic [CfgW-1:0]            cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SampleW-1:0]  mix_left  = '0;
  logic signed [SampleW-1:0]  mix_right = '0;
  logic                       block_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [PcmW-1:0]     out_left;
  logic signed [PcmW-1:0]     out_right;
  logic                       block_last;

  int          mismatches;
  int          pending;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int          hold_reqs    = 0;
  int unsigned cycle_cnt    = 0;

  always #6 clk_i = ~clk_i;

  stereo_lowpass_output_stage dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mix_left_i   (mix_left),
    .mix_right_i  (mix_right),
    .block_end_i  (block_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_left_o   (out_left),
    .out_right_o  (out_right),
    .block_last_o (block_last)
  );

  slpo_pcm_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .mix_left_i   (mix_left),
    .mix_right_i  (mix_right),
    .block_end_i  (block_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_left_i   (out_left),
    .out_right_i  (out_right),
    .block_last_i (block_last),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_reqs) begin
        hold_done = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // offer one stereo pair and wait for its transaction
  task automatic send_pair(input logic [SampleW-1:0] l, input logic [SampleW-1:0] r,
                           input logic e);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    mix_left  <= l;
    mix_right <= r;
    block_end <= e;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // stop offering and wait until every expected pair has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // register set, coefficient only on request, with junk in the unused data bits
  task automatic apply_setting(input logic on, input logic [CoefW-1:0] a,
                               input logic [FmtW-1:0] fmt, input bit with_coef);
    logic [CfgW-1:0] junk;
    settle();
    junk = CfgW'($urandom());
    if (with_coef) begin
      write_reg(CFG_COEF_A, a);
    end
    write_reg(CFG_FILTER_ON, {junk[CfgW-1:1], on});
    write_reg(CFG_OUT_FORMAT, {junk[CfgW-1:2], fmt});
    write_reg(CFG_UNUSED, ~junk);
  endtask

  // samples spread over full range, the 16-bit window edges and small values
  function automatic logic [SampleW-1:0] rand_sample();
    logic [SampleW-1:0] v;
    case ($urandom_range(7))
      0:       v = ($urandom_range(1) == 0) ? 32'h7fffffff : 32'h80000000;
      1, 2:    v = $urandom();
      3:       v = $urandom_range(32'h1fff) - 32'h1000;
      default: v = $urandom_range(32'h1200000) - 32'h900000;
    endcase
    return v;
  endfunction

  // stimulus
  initial begin
    logic [CoefW-1:0] a;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_gap_pct = 19;
    recv_gap_pct = 46;

    // bypass, 16-bit stereo: saturation and shift edges
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h00000000, 32'hffffffff, 1'b1);
    send_pair(32'h000000ff, 32'h00000100, 1'b0);
    send_pair(32'h007fff00, 32'hff800000, 1'b1);
    send_pair(32'h00800000, 32'hff7fff00, 1'b0);

    // mono, then both 8-bit formats; extra data bits are dropped
    settle();
    write_reg(CFG_OUT_FORMAT, 15'h7ff9);
    send_pair(32'h12345678, 32'h7fffffff, 1'b1);
    settle();
    write_reg(CFG_OUT_FORMAT, 15'h0002);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h00000000, 32'hffffffff, 1'b1);
    settle();
    write_reg(CFG_OUT_FORMAT, 15'h0003);
    send_pair(-32'sd3160320, 32'sd999999, 1'b0);

    // unused index is ignored
    settle();
    write_reg(CFG_UNUSED, 15'h7fff);
    write_reg(CFG_OUT_FORMAT, 15'h0000);

    // filter with zero coefficient passes the input through
    apply_setting(1'b1, 15'd0, 2'd0, 1'b1);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'hc0000000, 32'h3fffffff, 1'b1);

    // largest coefficient with full-scale swings between stages
    apply_setting(1'b1, 15'h7fff, 2'd0, 1'b1);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h80000000, 32'h7fffffff, 1'b0);
    send_pair(32'h80000000, 32'h7fffffff, 1'b1);

    // toggling filter_on with no pair between keeps the history
    settle();
    write_reg(CFG_FILTER_ON, 15'h7ffe);
    write_reg(CFG_FILTER_ON, 15'h0001);
    send_pair(32'h00000000, 32'h00000000, 1'b0);
    send_pair(32'h01000000, 32'hff000000, 1'b1);

    // smallest nonzero coefficient, 8-bit stereo
    apply_setting(1'b1, 15'd1, 2'd2, 1'b1);
    send_pair(32'h7fffffff, 32'h80000000, 1'b0);
    send_pair(32'h00123400, 32'hffedcc00, 1'b0);

    // a bypassed pair clears history, then filter again
    apply_setting(1'b0, 15'd1, 2'd0, 1'b0);
    send_pair(32'h00400000, 32'hffc00000, 1'b0);
    apply_setting(1'b1, 15'd1, 2'd0, 1'b0);
    send_pair(32'h00400000, 32'hffc00000, 1'b1);

    // random phases over a spread of settings and idling patterns
    for (int ph = 0; ph < NumPhases; ph++) begin
      a = CoefW'($urandom_range(32767));
      case (ph)
        0:       apply_setting(1'b1, 15'h7fff, 2'd0, 1'b1);
        1:       apply_setting(1'b1, a, 2'd1, 1'b1);
        2:       apply_setting(1'b0, a, 2'd2, 1'b1);
        3:       apply_setting(1'b1, 15'd0, 2'd3, 1'b1);
        4:       apply_setting(1'b1, a, 2'd2, 1'b0);
        5:       apply_setting(1'b1, 15'd1, 2'd0, 1'b1);
        6:       apply_setting(1'b1, a, 2'($urandom_range(3)), 1'b1);
        7:       apply_setting(1'b1, 15'h7fff, 2'd0, 1'b1);
        default: apply_setting(1'b1, a, 2'd3, 1'b1);
      endcase
      if (ph < 3) begin
        send_gap_pct = 19;
        recv_gap_pct = 46;
      end else if (ph < 6) begin
        send_gap_pct = 46;
        recv_gap_pct = 19;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      // long receiver hold-off so the block backs up into its input
      if (ph == 1 || ph == 7) begin
        hold_reqs++;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        send_pair(rand_sample(), rand_sample(), $urandom_range(3) == 0);
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
